// ----- sv/svwo_pkg.sv -----
package svwo_pkg;

  // Table geometry of one waveform cycle. The cycle length is a power of two,
  // so the table index is the top bits of the phase accumulator.
  localparam int unsigned TABLE_BITS = 8;
  localparam int unsigned TABLE_LEN  = 1 << TABLE_BITS;

  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned PHASE_MUL = 5719;
  localparam int unsigned NOISE_W   = 23;

  localparam int unsigned WAVE_PEAK   = 32766;
  localparam int unsigned PULSE_LEVEL = 32765;
  localparam int unsigned SAW_SPAN    = 65532;
  localparam int unsigned SAW_STEP    = SAW_SPAN / TABLE_LEN;
  localparam int unsigned DUTY_MAX    = 100;

  localparam int unsigned FREQ_W  = 16;
  localparam int unsigned PW_W    = 16;
  localparam int unsigned CTRL_W  = 8;
  localparam int unsigned ENV_W   = 8;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Waveform select bits of the control byte, in priority order.
  localparam int unsigned CTRL_TRI_BIT   = 4;
  localparam int unsigned CTRL_SAW_BIT   = 5;
  localparam int unsigned CTRL_PULSE_BIT = 6;
  localparam int unsigned CTRL_NOISE_BIT = 7;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREQ_WORD        = 2'd0,
    CFG_PULSE_WIDTH      = 2'd1,
    CFG_WAVEFORM_CONTROL = 2'd2
  } cfg_reg_e;

  // One classified tick: the waveform value and the envelope to scale it by.
  typedef struct packed {
    logic signed [SMP_W-1:0] wave;
    logic [ENV_W-1:0]        env;
  } svwo_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } svwo_qstat_t;

endpackage

// ----- sv/sid_voice_waveform_oscillator_top.sv -----
// One oscillator voice: a phase accumulator driving a triangle, sawtooth,
// pulse or noise waveform, scaled by an envelope level.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 frequency word, 1 pulse width, 2 waveform control) at a clock edge;
// other indexes are ignored. Write only while the voice is idle.
// Input channel: each transaction carries one envelope level and yields
// exactly one signed 16-bit sample on the output channel, in order.
// The front stage samples the waveform at the current phase, then advances
// the phase; the noise register steps only on ticks that select noise.
// A two-entry queue separates it from the back stage, which multiplies by
// the envelope into the output register.
// Each sample is written into the queue, then registered in the output register.
// Throughput: one transaction per cycle while the queue is not full, set by
// the single back-stage multiplier and the registered front-stage phase update.
// When the receiver stalls, the output register holds and the queue fills;
// input ready drops only once the queue is full.
// Reset clears the registers and the phase, sets the noise register to all
// ones and empties the queue and output register.
module sid_voice_waveform_oscillator_top #(
  parameter int unsigned QUEUE_DEPTH = svwo_pkg::QUEUE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [svwo_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [svwo_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [svwo_pkg::ENV_W-1:0]         envelope_level_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [svwo_pkg::SMP_W-1:0]  sample_o
);
  import svwo_pkg::*;

  svwo_job_t   push_job, head_job;
  svwo_qstat_t qstat;
  logic        push, pop;

  svwo_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .envelope_level_i (envelope_level_i),
    .qstat_i          (qstat),
    .push_o           (push),
    .job_o            (push_job)
  );

  svwo_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (qstat)
  );

  svwo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_o)
  );

endmodule

// ----- sv/svwo_front.sv -----
module svwo_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [svwo_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [svwo_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [svwo_pkg::ENV_W-1:0]         envelope_level_i,
  input  svwo_pkg::svwo_qstat_t              qstat_i,
  output logic                               push_o,
  output svwo_pkg::svwo_job_t                job_o
);
  import svwo_pkg::*;

  localparam int unsigned Q_BITS = TABLE_BITS - 2;
  localparam logic [TABLE_BITS-1:0] IDX_Q  = TABLE_BITS'(TABLE_LEN / 4);
  localparam logic [TABLE_BITS-1:0] IDX_2Q = TABLE_BITS'(TABLE_LEN / 2);
  localparam logic [TABLE_BITS-1:0] IDX_3Q = TABLE_BITS'(3 * (TABLE_LEN / 4));
  localparam logic signed [SMP_W-1:0] WAVE_MIN = -$signed(SMP_W'(WAVE_PEAK));

  logic [FREQ_W-1:0]  freq_q;
  logic [PW_W-1:0]    pw_q;
  logic [CTRL_W-1:0]  ctrl_q;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [NOISE_W-1:0] noise_q, noise_d, noise_next;

  logic [TABLE_BITS-1:0] idx;
  logic [TABLE_BITS-1:0] tri_mag;
  logic                  tri_neg;
  logic [31:0]           tri_scaled;
  logic signed [SMP_W-1:0] tri_pos, tri_wave;
  logic signed [17:0]    saw_full;
  logic signed [SMP_W-1:0] saw_wave;
  logic [31:0]           duty_raw;
  logic [6:0]            duty;
  logic                  pulse_hi;
  logic signed [SMP_W-1:0] pulse_wave;
  logic signed [SMP_W-1:0] noise_raw, noise_wave;
  logic signed [SMP_W-1:0] wave;
  logic                  use_noise;

  assign in_ready_o = !qstat_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  assign idx = phase_q[PHASE_W-1 -: TABLE_BITS];

  // Triangle: rising first quarter, falling middle half, rising last quarter.
  always_comb begin
    if (idx < IDX_Q) begin
      tri_mag = idx;
      tri_neg = 1'b0;
    end else if (idx <= IDX_2Q) begin
      tri_mag = IDX_2Q - idx;
      tri_neg = 1'b0;
    end else if (idx < IDX_3Q) begin
      tri_mag = idx - IDX_2Q;
      tri_neg = 1'b1;
    end else begin
      tri_mag = ~idx + TABLE_BITS'(1);
      tri_neg = 1'b1;
    end
  end

  assign tri_scaled = (32'(WAVE_PEAK) * 32'(tri_mag)) >> Q_BITS;
  assign tri_pos    = (tri_scaled > 32'(WAVE_PEAK)) ? SMP_W'(WAVE_PEAK)
                                                    : tri_scaled[SMP_W-1:0];
  assign tri_wave   = tri_neg ? -tri_pos : tri_pos;

  assign saw_full = 18'(WAVE_PEAK) - 18'(idx) * 18'(SAW_STEP);
  assign saw_wave = saw_full[SMP_W-1:0];

  // The pulse is high while idx < floor(TABLE_LEN * duty / 100), which holds
  // exactly when 100 * (idx + 1) <= TABLE_LEN * duty.
  assign duty_raw   = (32'(pw_q) * 32'(DUTY_MAX)) >> 12;
  assign duty       = (duty_raw > 32'(DUTY_MAX)) ? 7'(DUTY_MAX) : duty_raw[6:0];
  assign pulse_hi   = ((32'(idx) + 32'd1) * 32'(DUTY_MAX)) <= (32'(TABLE_LEN) * 32'(duty));
  assign pulse_wave = pulse_hi ? SMP_W'(PULSE_LEVEL) : -SMP_W'(PULSE_LEVEL);

  assign noise_next = {noise_q[NOISE_W-2:0], noise_q[NOISE_W-1] ^ noise_q[17]};
  // Subtracting 32768 from the unsigned field is a flip of its top bit.
  assign noise_raw  = {~noise_next[NOISE_W-1], noise_next[NOISE_W-2:7]};
  assign noise_wave = (noise_raw < WAVE_MIN) ? WAVE_MIN : noise_raw;

  always_comb begin
    use_noise = 1'b0;
    if (ctrl_q[CTRL_TRI_BIT]) begin
      wave = tri_wave;
    end else if (ctrl_q[CTRL_SAW_BIT]) begin
      wave = saw_wave;
    end else if (ctrl_q[CTRL_PULSE_BIT]) begin
      wave = pulse_wave;
    end else if (ctrl_q[CTRL_NOISE_BIT]) begin
      wave      = noise_wave;
      use_noise = 1'b1;
    end else begin
      wave = '0;
    end
  end

  assign job_o.wave = wave;
  assign job_o.env  = envelope_level_i;

  assign phase_d = push_o ? phase_q + 32'(freq_q) * 32'(PHASE_MUL) : phase_q;
  assign noise_d = (push_o && use_noise) ? noise_next : noise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q  <= '0;
      pw_q    <= '0;
      ctrl_q  <= '0;
      phase_q <= '0;
      noise_q <= '1;
    end else begin
      phase_q <= phase_d;
      noise_q <= noise_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FREQ_WORD:        freq_q <= cfg_wdata_i[FREQ_W-1:0];
          CFG_PULSE_WIDTH:      pw_q   <= cfg_wdata_i[PW_W-1:0];
          CFG_WAVEFORM_CONTROL: ctrl_q <= cfg_wdata_i[CTRL_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- sv/svwo_queue.sv -----
module svwo_queue #(
  parameter int unsigned DEPTH = svwo_pkg::QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  svwo_pkg::svwo_job_t    job_i,
  input  logic                   pop_i,
  output svwo_pkg::svwo_job_t    job_o,
  output svwo_pkg::svwo_qstat_t  stat_o
);
  import svwo_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  svwo_job_t        slot_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign job_o        = slot_q[rd_q];
  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ----- sv/svwo_back.sv -----
module svwo_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  svwo_pkg::svwo_job_t            job_i,
  input  svwo_pkg::svwo_qstat_t          qstat_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [svwo_pkg::SMP_W-1:0] sample_o
);
  import svwo_pkg::*;

  logic                    valid_q;
  logic signed [SMP_W-1:0] sample_q;
  logic signed [24:0]      prod;

  // An arithmetic shift of the product rounds toward minus infinity.
  assign prod  = job_i.wave * $signed({1'b0, job_i.env});
  assign pop_o = !qstat_i.empty && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sample_q <= prod[SMP_W+7:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign sample_o    = sample_q;

endmodule
